// ===== hw/rtl/sws_pkg.sv =====
// Package for the stop-and-wait sender: payload structs, item kinds and constants.
// Used by the front, back and top modules of the block; depends on nothing.
package sws_pkg;

   localparam int DATA_BYTES = 10;   // data bytes carried by one packet (1 to 10)
   localparam int MAX_BYTES  = 10;   // data bytes that the field layout holds

   localparam logic [1:0] MODE_NEW  = 2'd0;
   localparam logic [1:0] MODE_ACK  = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_LIMIT   = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [7:0]  LIMIT_RESET   = 8'd3;
   localparam logic [15:0] TICK_MAX      = 16'hffff;
   localparam logic [7:0]  TRY_MAX       = 8'hff;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_NEW  = 2'd1,
      KIND_ACK  = 2'd2,
      KIND_TICK = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  length;
      logic [63:0] data_low;
      logic [15:0] data_high;
      logic [31:0] ack_seq;
      logic [31:0] ack_length;
      logic [7:0]  ack_checksum;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic        send_seq;
      logic [3:0]  send_length;
      logic [7:0]  send_checksum;
      logic [63:0] send_data_low;
      logic [15:0] send_data_high;
      logic        acked;
      logic        gave_up;
      logic        waiting;
   } rsp_type;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  length;      // saturated length of a new packet
      logic [63:0] data_low;    // bytes as they will be held
      logic [15:0] data_high;
      logic [7:0]  data_sum;    // XOR of data bytes before the first zero byte
      logic        ack_sum_ok;  // carried ACK checksum matches the recomputed one
      logic        ack_seq_0;   // ACK sequence field is exactly 0
      logic        ack_seq_1;   // ACK sequence field is exactly 1
   } item_type;

endpackage

// ===== hw/rtl/sws_fifo.sv =====
// Two-entry register queue with a registered count, used for items and results.
// Depends on nothing; the entry width is a parameter.
module sws_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sws_front.sv =====
// Front part of the stop-and-wait sender: classifies an incoming item and does the
// state-free checksum work. Depends on sws_pkg.
module sws_front (
   input  sws_pkg::req_type  req,
   output sws_pkg::item_type item
);

   logic [7:0]  bytes [sws_pkg::MAX_BYTES];
   logic [79:0] raw;
   logic [7:0]  sum;
   logic        run;
   logic [3:0]  len_sat;
   logic        zero_fill;
   logic [63:0] lo;
   logic [15:0] hi;

   function automatic logic [7:0] word_xor(input logic [31:0] w);
      return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
   endfunction

   always_comb begin
      len_sat = (req.length > 4'(sws_pkg::DATA_BYTES)) ? 4'(sws_pkg::DATA_BYTES) : req.length;
      // A new empty packet carries all-zero data.
      zero_fill = (req.mode == sws_pkg::MODE_NEW) && (len_sat == 4'd0);
      raw       = {req.data_high, req.data_low};

      for (int i = 0; i < sws_pkg::MAX_BYTES; i++) begin
         if (i < sws_pkg::DATA_BYTES && !zero_fill) begin
            bytes[i] = raw[8*i +: 8];
         end else begin
            bytes[i] = 8'h00;
         end
      end

      sum = 8'h00;
      run = 1'b1;
      for (int i = 0; i < sws_pkg::MAX_BYTES; i++) begin
         run = run && (bytes[i] != 8'h00);
         if (run) begin
            sum = sum ^ bytes[i];
         end
      end

      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = bytes[i];
      end
      hi = {bytes[9], bytes[8]};

      case (req.mode)
         sws_pkg::MODE_NEW:  item.kind = sws_pkg::KIND_NEW;
         sws_pkg::MODE_ACK:  item.kind = sws_pkg::KIND_ACK;
         sws_pkg::MODE_TICK: item.kind = sws_pkg::KIND_TICK;
         default:            item.kind = sws_pkg::KIND_NONE;
      endcase
      item.length     = len_sat;
      item.data_low   = lo;
      item.data_high  = hi;
      item.data_sum   = sum;
      item.ack_sum_ok = (req.ack_checksum ==
                         (word_xor(req.ack_seq) ^ word_xor(req.ack_length) ^ sum));
      item.ack_seq_0  = (req.ack_seq == 32'd0);
      item.ack_seq_1  = (req.ack_seq == 32'd1);
   end

endmodule

// ===== hw/rtl/sws_back.sv =====
// Back part of the stop-and-wait sender: holds the protocol state, applies one
// item per cycle while rsp_room is high, forms its result. Depends on sws_pkg.
module sws_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  sws_pkg::item_type item,
   input  logic              rsp_room,
   input  logic [15:0]       timeout_ticks,
   input  logic [7:0]        final_try_limit,
   output logic              item_take,
   output sws_pkg::rsp_type  rsp
);

   logic        seq_ff, seq_in;
   logic        busy_ff, busy_in;
   logic [3:0]  len_ff, len_in;
   logic [7:0]  chk_ff, chk_in;
   logic [63:0] lo_ff, lo_in;
   logic [15:0] hi_ff, hi_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  try_ff, try_in;
   logic        do_resend;
   logic        ack_good;
   logic [15:0] tick_next;

   assign item_take = item_valid && rsp_room;

   always_comb begin
      seq_in    = seq_ff;
      busy_in   = busy_ff;
      len_in    = len_ff;
      chk_in    = chk_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      tick_in   = tick_ff;
      try_in    = try_ff;
      do_resend = 1'b0;
      rsp       = '0;
      ack_good  = (seq_ff ? item.ack_seq_1 : item.ack_seq_0) && item.ack_sum_ok;
      tick_next = (tick_ff < sws_pkg::TICK_MAX) ? tick_ff + 16'd1 : tick_ff;

      case (item.kind)
         sws_pkg::KIND_NEW: begin
            if (!busy_ff) begin
               len_in  = item.length;
               lo_in   = item.data_low;
               hi_in   = item.data_high;
               chk_in  = {7'd0, seq_ff} ^ {4'd0, item.length} ^ item.data_sum;
               busy_in = 1'b1;
               tick_in = 16'd0;
               try_in  = 8'd1;
               rsp.send_valid     = 1'b1;
               rsp.send_seq       = seq_ff;
               rsp.send_length    = item.length;
               rsp.send_checksum  = chk_in;
               rsp.send_data_low  = item.data_low;
               rsp.send_data_high = item.data_high;
            end
         end
         sws_pkg::KIND_ACK: begin
            if (busy_ff) begin
               if (ack_good) begin
                  seq_in    = ~seq_ff;
                  busy_in   = 1'b0;
                  tick_in   = 16'd0;
                  rsp.acked = 1'b1;
               end else begin
                  do_resend = 1'b1;
               end
            end
         end
         sws_pkg::KIND_TICK: begin
            if (busy_ff) begin
               tick_in   = tick_next;
               do_resend = (tick_next >= timeout_ticks);
            end
         end
         default: begin
         end
      endcase

      if (do_resend) begin
         tick_in = 16'd0;
         if (len_ff == 4'd0 && try_ff >= final_try_limit) begin
            busy_in     = 1'b0;
            rsp.gave_up = 1'b1;
         end else begin
            try_in = (try_ff < sws_pkg::TRY_MAX) ? try_ff + 8'd1 : try_ff;
            rsp.send_valid     = 1'b1;
            rsp.send_seq       = seq_ff;
            rsp.send_length    = len_ff;
            rsp.send_checksum  = chk_ff;
            rsp.send_data_low  = lo_ff;
            rsp.send_data_high = hi_ff;
         end
      end
      rsp.waiting = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= 1'b0;
         busy_ff <= 1'b0;
         len_ff  <= 4'd0;
         chk_ff  <= 8'd0;
         tick_ff <= 16'd0;
         try_ff  <= 8'd0;
      end else if (item_take) begin
         seq_ff  <= seq_in;
         busy_ff <= busy_in;
         len_ff  <= len_in;
         chk_ff  <= chk_in;
         tick_ff <= tick_in;
         try_ff  <= try_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

endmodule

// ===== hw/rtl/stop_and_wait_sender_unit.sv =====
// Top level of the alternating-bit stop-and-wait sender.
// Depends on sws_pkg, sws_fifo, sws_front and sws_back.
//
// Usage:
//   Items enter on the req_ queue port: an item is taken at a clock edge where
//   req_push is high and req_full is low. Each item is a new packet, an ACK or
//   one timer tick (mode 3 is ignored), and each produces exactly one result item.
//   Results leave on the rsp_ queue port: the oldest result sits on rsp_data
//   while rsp_empty is low and is taken at an edge where rsp_pop is high.
//   The two registers (timeout ticks, final try limit) are written through the
//   csr_ port, which is always ready; write them only while the block is idle.
//
// Timing: an item is classified and checked in the cycle it is taken and lands
// in a two-entry queue; the protocol state unit applies one item per cycle while
// the result queue has room, and writes the result into a two-entry result queue.
// A result can be popped once its item has passed the item queue and back part;
// the block sustains one item per cycle while results are popped.
// When the receiver stops popping, the result queue fills, the state unit holds,
// then the item queue fills and req_full rises; nothing is lost.
// Reset clears the sequence bit, the busy flag, the counters and both queues, and
// returns the registers to 2000 ticks and 3 tries.
module stop_and_wait_sender_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sws_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sws_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   sws_pkg::item_type front_item;
   sws_pkg::item_type back_item;
   sws_pkg::rsp_type  back_rsp;
   logic              item_empty;
   logic              item_take;
   logic              rsp_full;
   logic [15:0]       timeout_ff, timeout_in;
   logic [7:0]        limit_ff, limit_in;

   // Configuration registers; the port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      limit_in   = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            sws_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            sws_pkg::CSR_LIMIT:   limit_in   = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sws_pkg::TIMEOUT_RESET;
         limit_ff   <= sws_pkg::LIMIT_RESET;
      end else begin
         timeout_ff <= timeout_in;
         limit_ff   <= limit_in;
      end
   end

   // Front part: classification and checksum work that needs no state.
   sws_front u_front (
      .req  (req_data),
      .item (front_item)
   );

   // Queue between the front and back parts.
   sws_fifo #(
      .WIDTH ($bits(sws_pkg::item_type))
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (item_take),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   // Back part: protocol state and result forming.
   sws_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (!item_empty),
      .item            (back_item),
      .rsp_room        (!rsp_full),
      .timeout_ticks   (timeout_ff),
      .final_try_limit (limit_ff),
      .item_take       (item_take),
      .rsp             (back_rsp)
   );

   // Result queue toward the receiver.
   sws_fifo #(
      .WIDTH ($bits(sws_pkg::rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_take),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

// ===== bench/sws_checker.sv =====
// Checksum helper package and scoreboard for the stop-and-wait sender bench.
// Depends on sws_pkg; the scoreboard predicts every result and compares it.
`timescale 1ns / 1ps

package sws_bench_pkg;
   import sws_pkg::*;

   function automatic logic [7:0] fold_word(input logic [31:0] w);
      return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
   endfunction

   // XOR over a sequence word, a length word and the data bytes that come
   // before the first zero byte.
   function automatic logic [7:0] frame_sum(input logic [31:0] seq, input logic [31:0] len,
                                            input logic [63:0] lo, input logic [15:0] hi);
      logic [79:0] raw;
      logic [7:0]  x;
      raw = {hi, lo};
      x = fold_word(seq) ^ fold_word(len);
      for (int i = 0; i < DATA_BYTES; i++) begin
         if (raw[8*i +: 8] == 8'd0)
            break;
         x ^= raw[8*i +: 8];
      end
      return x;
   endfunction
endpackage

module sws_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  sws_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  sws_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   output int               mismatches,
   output int               outstanding,
   output logic             sender_seq
);
   import sws_pkg::*;
   import sws_bench_pkg::*;

   logic [15:0] timeout_reg;
   logic [7:0]  limit_reg;
   logic        alt_bit;
   logic        in_flight;
   logic [3:0]  held_len;
   logic [63:0] held_low;
   logic [15:0] held_high;
   logic [7:0]  held_sum;
   logic [15:0] ticks_waited;
   logic [7:0]  sends_made;

   rsp_type expected_results[$];
   rsp_type want;

   initial mismatches = 0;

   function automatic rsp_type held_frame();
      rsp_type o;
      o = '0;
      o.send_valid     = 1'b1;
      o.send_seq       = alt_bit;
      o.send_length    = held_len;
      o.send_checksum  = held_sum;
      o.send_data_low  = held_low;
      o.send_data_high = held_high;
      return o;
   endfunction

   // A failed attempt: drop an empty final packet once it has used up its
   // tries, otherwise send the held packet again.
   function automatic rsp_type retry_held();
      rsp_type o;
      o = '0;
      ticks_waited = '0;
      if (held_len == 4'd0 && sends_made >= limit_reg) begin
         in_flight = 1'b0;
         o.gave_up = 1'b1;
      end else begin
         if (sends_made != TRY_MAX)
            sends_made++;
         o = held_frame();
      end
      return o;
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type     o;
      logic [3:0]  len;
      logic [79:0] raw;
      o = '0;
      if (r.mode == MODE_NEW && !in_flight) begin
         len = r.length;
         if (r.length > DATA_BYTES)
            len = 4'(DATA_BYTES);
         raw = {r.data_high, r.data_low};
         if (len == 4'd0)
            raw = '0;
         for (int i = DATA_BYTES; i < MAX_BYTES; i++)
            raw[8*i +: 8] = 8'd0;
         held_len     = len;
         held_low     = raw[63:0];
         held_high    = raw[79:64];
         held_sum     = frame_sum({31'd0, alt_bit}, {28'd0, len}, held_low, held_high);
         in_flight    = 1'b1;
         ticks_waited = '0;
         sends_made   = 8'd1;
         o = held_frame();
      end else if (r.mode == MODE_ACK && in_flight) begin
         if (r.ack_seq == {31'd0, alt_bit} &&
             r.ack_checksum == frame_sum(r.ack_seq, r.ack_length, r.data_low, r.data_high)) begin
            alt_bit      = ~alt_bit;
            in_flight    = 1'b0;
            ticks_waited = '0;
            o.acked      = 1'b1;
         end else begin
            o = retry_held();
         end
      end else if (r.mode == MODE_TICK && in_flight) begin
         if (ticks_waited != TICK_MAX)
            ticks_waited++;
         if (ticks_waited >= timeout_reg)
            o = retry_held();
      end
      o.waiting = in_flight;
      return o;
   endfunction

   function automatic void report_if_wrong(input string what, input logic [63:0] exp_val,
                                           input logic [63:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s wrong, expected %0h, actual %0h", $time, what, exp_val, got_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timeout_reg  = TIMEOUT_RESET;
         limit_reg    = LIMIT_RESET;
         alt_bit      = 1'b0;
         in_flight    = 1'b0;
         held_len     = '0;
         held_low     = '0;
         held_high    = '0;
         held_sum     = '0;
         ticks_waited = '0;
         sends_made   = '0;
         expected_results.delete();
      end else begin
         // Results pass through both queues behind their items, so the popped
         // result is always older than any item taken at this edge.
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected, actual %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               report_if_wrong("send_valid", 64'(want.send_valid),
                               64'(rsp_data.send_valid));
               report_if_wrong("send_seq", 64'(want.send_seq), 64'(rsp_data.send_seq));
               report_if_wrong("send_length", 64'(want.send_length),
                               64'(rsp_data.send_length));
               report_if_wrong("send_checksum", 64'(want.send_checksum),
                               64'(rsp_data.send_checksum));
               report_if_wrong("send_data_low", want.send_data_low, rsp_data.send_data_low);
               report_if_wrong("send_data_high", 64'(want.send_data_high),
                               64'(rsp_data.send_data_high));
               report_if_wrong("acked", 64'(want.acked), 64'(rsp_data.acked));
               report_if_wrong("gave_up", 64'(want.gave_up), 64'(rsp_data.gave_up));
               report_if_wrong("waiting", 64'(want.waiting), 64'(rsp_data.waiting));
            end
         end
         if (req_push && !req_full)
            expected_results.push_back(predict_result(req_data));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TIMEOUT)
               timeout_reg = csr_wdata;
            else
               limit_reg = csr_wdata[7:0];
         end
      end
      outstanding <= expected_results.size();
      sender_seq  <= alt_bit;
   end

endmodule

// ===== bench/tb_stop_and_wait_sender_unit.sv =====
// Top of the stop-and-wait sender bench: clock, reset, stimulus and verdict.
// Depends on sws_pkg, sws_bench_pkg and sws_checker, plus the block itself.
`timescale 1ns / 1ps

module tb_stop_and_wait_sender_unit;
   import sws_pkg::*;
   import sws_bench_pkg::*;

   // Mode value that the block must ignore.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Ways an ACK item can be built: correct, or broken in one field.
   typedef enum int {
      ACK_GOOD,
      ACK_BAD_SUM,
      ACK_WRONG_SEQ,
      ACK_HIGH_SEQ
   } ack_flaw_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        req_full;
   req_type     req_data  = '0;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   int   mismatches;
   int   outstanding;
   logic sender_seq;

   // Percentages of cycles in which the sender and the receiver hold back.
   int tx_idle_pct = 12;
   int rx_idle_pct = 61;
   int items_sent  = 0;

   // Register settings of the random phases, extremes and zero among them.
   // One limit write carries junk in the upper byte, which the block drops.
   logic [15:0] phase_timeout [6] = '{16'd1, 16'hffff, 16'd0, 16'd3, 16'd2, 16'd6};
   logic [15:0] phase_limit   [6] = '{16'h0001, 16'h00ff, 16'h0000, 16'h5502, 16'h0004,
                                      16'h0003};

   stop_and_wait_sender_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sws_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .sender_seq  (sender_seq)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver decides afresh every cycle whether it takes a result.
   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Every field random, so that every input bit sees both values.
   function automatic req_type random_req();
      req_type r;
      r.mode         = 2'($urandom_range(3));
      r.length       = 4'($urandom);
      r.data_low     = {$urandom, $urandom};
      r.data_high    = 16'($urandom);
      r.ack_seq      = $urandom;
      r.ack_length   = $urandom;
      r.ack_checksum = 8'($urandom);
      return r;
   endfunction

   // Ten random data bytes; often one of them is zero, which cuts the
   // checksum short at that byte.
   function automatic logic [79:0] payload_bytes();
      logic [79:0] raw;
      raw = 80'({$urandom, $urandom, $urandom});
      if ($urandom_range(2) == 0)
         raw[8*$urandom_range(9) +: 8] = 8'd0;
      return raw;
   endfunction

   // An ACK for the given sequence bit, with a correct checksum unless the
   // flaw asks for a bad one. Sequence flaws keep the checksum consistent so
   // that only the sequence compare fails.
   function automatic req_type ack_item(input logic seq, input ack_flaw_type flaw);
      req_type     r;
      logic [79:0] raw;
      r   = random_req();
      raw = payload_bytes();
      r.mode      = MODE_ACK;
      r.data_low  = raw[63:0];
      r.data_high = raw[79:64];
      r.ack_seq   = {31'd0, seq};
      if (flaw == ACK_WRONG_SEQ)
         r.ack_seq[0] = ~seq;
      if (flaw == ACK_HIGH_SEQ) begin
         r.ack_seq[31:1] = 31'($urandom);
         r.ack_seq[1 + $urandom_range(30)] = 1'b1;
      end
      r.ack_checksum = frame_sum(r.ack_seq, r.ack_length, r.data_low, r.data_high);
      if (flaw == ACK_BAD_SUM)
         r.ack_checksum ^= 8'($urandom_range(255, 1));
      return r;
   endfunction

   // Offers one item and returns at the edge where the block takes it. The
   // push line is left high so that the next item can follow without a gap.
   task automatic send_item(input req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_mode(input logic [1:0] mode);
      req_type r;
      r = random_req();
      r.mode = mode;
      send_item(r);
   endtask

   // Stops the sender until every expected result has been taken, then lets
   // the block run out its pipeline. The first edge makes sure the count
   // already includes the last item taken.
   task automatic settle();
      req_push <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One exchange as a real link would run it: a new packet, some failed
   // attempts (timer ticks or broken ACKs), usually a good ACK, and a closing
   // tick. The closing tick normally finds the block idle and is ignored; it
   // also lets the predicted sequence bit catch up before the next exchange.
   // The burst form sends an empty final packet and breaks every ACK so that
   // the try counter runs all the way to the limit.
   task automatic run_exchange(input bit burst);
      req_type      r;
      logic         seq;
      int           pick;
      int           fails;
      ack_flaw_type flaw;
      logic [79:0]  raw;
      seq  = sender_seq;
      r    = random_req();
      raw  = payload_bytes();
      pick = $urandom_range(99);
      r.mode      = MODE_NEW;
      r.data_low  = raw[63:0];
      r.data_high = raw[79:64];
      if (burst || pick < 15)
         r.length = 4'd0;
      else if (pick < 25)
         r.length = 4'($urandom_range(15, 11));
      else
         r.length = 4'($urandom_range(10, 1));
      if (burst)
         fails = 258;
      else if ($urandom_range(3) == 0)
         fails = $urandom_range(6);
      else
         fails = $urandom_range(1);
      send_item(r);
      repeat (fails) begin
         if (!burst && $urandom_range(1) == 0) begin
            send_mode(MODE_TICK);
         end else begin
            case ($urandom_range(2))
               0: flaw = ACK_BAD_SUM;
               1: flaw = ACK_WRONG_SEQ;
               default: flaw = ACK_HIGH_SEQ;
            endcase
            if (burst)
               flaw = ACK_BAD_SUM;
            send_item(ack_item(seq, flaw));
         end
      end
      if (!burst && $urandom_range(99) < 85)
         send_item(ack_item(seq, ACK_GOOD));
      send_mode(MODE_TICK);
   endtask

   initial begin
      req_type r;
      int      target;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A short timeout and a try limit of two make resends
      // and abandoning happen within a few items.
      write_reg(CSR_TIMEOUT, 16'd2);
      write_reg(CSR_LIMIT, 16'd2);

      // Items at the wrong time while idle: tick, ACK and the unused mode.
      send_mode(MODE_TICK);
      send_mode(MODE_ACK);
      send_mode(MODE_UNUSED);

      // Full-length packet with every data bit set, then a new packet while
      // busy and the unused mode while busy, both ignored, then a good ACK.
      r = random_req();
      r.mode      = MODE_NEW;
      r.length    = 4'd10;
      r.data_low  = '1;
      r.data_high = '1;
      send_item(r);
      send_mode(MODE_NEW);
      send_mode(MODE_UNUSED);
      send_item(ack_item(1'b0, ACK_GOOD));

      // Length beyond ten saturates, and the zero fifth byte stops the
      // checksum. An ACK whose upper sequence bits are set is rejected, two
      // ticks expire the timer, then a good ACK for sequence one.
      r = random_req();
      r.mode      = MODE_NEW;
      r.length    = 4'hf;
      r.data_low  = 64'h1122_3300_4455_6677;
      r.data_high = 16'habcd;
      send_item(r);
      send_item(ack_item(1'b1, ACK_HIGH_SEQ));
      send_mode(MODE_TICK);
      send_mode(MODE_TICK);
      send_item(ack_item(1'b1, ACK_GOOD));

      // Empty final packet: sent with zero data although data is offered,
      // resent on timeout, then abandoned on a bad ACK at the try limit.
      r = random_req();
      r.mode     = MODE_NEW;
      r.length   = 4'd0;
      r.data_low = 64'h0102_0304_0506_0708;
      send_item(r);
      send_mode(MODE_TICK);
      send_mode(MODE_TICK);
      send_item(ack_item(1'b0, ACK_BAD_SUM));
      send_mode(MODE_TICK);

      // One-byte packet whose only byte is zero; the ACK with the wrong
      // sequence bit forces a resend before the good one.
      r = random_req();
      r.mode     = MODE_NEW;
      r.length   = 4'd1;
      r.data_low = '0;
      send_item(r);
      send_item(ack_item(1'b0, ACK_WRONG_SEQ));
      send_item(ack_item(1'b0, ACK_GOOD));

      // Both registers at zero: every tick expires, and an empty packet is
      // given up at its first failure while a filled one is resent.
      settle();
      write_reg(CSR_TIMEOUT, 16'd0);
      write_reg(CSR_LIMIT, 16'd0);
      r = random_req();
      r.mode   = MODE_NEW;
      r.length = 4'd0;
      send_item(r);
      send_mode(MODE_TICK);
      r.length = 4'd3;
      send_item(r);
      send_mode(MODE_TICK);

      // Random part: six register settings, the first pair with little sender-side
      // idle and a receiver that often holds back, the second pair the other way
      // round, the last pair with no idling at all. Each phase starts from a
      // fully drained block, which is also where the sender waits for every
      // expected result to come back.
      for (int p = 0; p < 6; p++) begin
         settle();
         write_reg(CSR_TIMEOUT, phase_timeout[p]);
         write_reg(CSR_LIMIT, phase_limit[p]);
         case (p / 2)
            0: begin
               tx_idle_pct = 12;
               rx_idle_pct = 61;
            end
            1: begin
               tx_idle_pct = 61;
               rx_idle_pct = 12;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         // With the largest try limit, an empty packet is driven to the limit
         // once. The ACK in front frees the block if a packet is still held.
         if (phase_limit[p][7:0] == TRY_MAX) begin
            send_item(ack_item(sender_seq, ACK_GOOD));
            run_exchange(1'b1);
         end
         target = items_sent + 150;
         while (items_sent < target) begin
            if ($urandom_range(99) < 15)
               send_item(random_req());
            else
               run_exchange(1'b0);
         end
      end

      settle();
      if (mismatches == 0)
         $display("stop_and_wait_sender_unit: match");
      else
         $display("stop_and_wait_sender_unit: mismatch");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #2_000_000;
      $display("stop_and_wait_sender_unit: mismatch");
      $finish;
   end

endmodule
